@@ rtl/core/mbsp_pkg.sv @@
package mbsp_pkg;

  localparam int PORT_W  = 2;
  localparam int PORTS   = 4;
  localparam int CHUNK   = 64;
  localparam int CNT_W   = 6;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

  localparam logic [7:0] ST_REALTIME = 8'hF8;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_EOX      = 8'hF7;
  localparam logic [7:0] ST_PROG     = 8'hC0;
  localparam logic [7:0] ST_PRESSURE = 8'hD0;
  localparam logic [7:0] ST_MTC      = 8'hF1;
  localparam logic [7:0] ST_SONGPOS  = 8'hF2;
  localparam logic [7:0] ST_SONGSEL  = 8'hF3;
  localparam logic [7:0] HI_NIBBLE   = 8'hF0;

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_SYSEX = 1'b1;

  // Parser context of one port, one memory word.
  typedef struct packed {
    logic [7:0]       live_status;
    logic [7:0]       held_status;
    logic [7:0]       held_data;
    logic [1:0]       byte_index;
    logic [1:0]       expected_len;
    logic             sysex_active;
    logic [CNT_W-1:0] chunk_count;
  } mbsp_state_t;

  typedef struct packed {
    logic              emit;
    logic [PORT_W-1:0] port;
    logic              kind;
    logic [1:0]        msg_len;
    logic [7:0]        byte0;
    logic [7:0]        byte1;
    logic [7:0]        byte2;
    logic              chunk_end;
    logic              sysex_end;
  } mbsp_res_t;

  // Total length of the message that a status byte opens; zero for data and SysEx start.
  function automatic logic [1:0] msg_length(input logic [7:0] s);
    logic [7:0] t;
    logic [1:0] len;
    t = s & HI_NIBBLE;
    if (!s[7]) begin
      len = 2'd0;
    end else if (s < ST_SYSEX) begin
      len = (t == ST_PROG || t == ST_PRESSURE) ? 2'd2 : 2'd3;
    end else if (s >= ST_REALTIME) begin
      len = 2'd1;
    end else if (s == ST_SYSEX) begin
      len = 2'd0;
    end else if (s == ST_SONGPOS) begin
      len = 2'd3;
    end else if (s == ST_MTC || s == ST_SONGSEL) begin
      len = 2'd2;
    end else begin
      len = 2'd1;
    end
    return len;
  endfunction

endpackage

@@ rtl/core/midi_byte_stream_parser_core.sv @@
// Pipeline: an accepted byte is held in the s1 registers, its result in out_r for out_*.
// Throughput: one byte per cycle while out_tready does not stall, bytes of the same port
// back to back too; the per-port context memory is read at accept and written from s1,
// and a forwarding register covers a read that meets the write to the same port.
// Reset: synchronous, active low; per-port valid flags all clear at once, no sweep.
module midi_byte_stream_parser_core
  import mbsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] rx_port, [9:2] rx_byte, zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [1:0] out_port, [3:2] msg_len, [11:4] byte0,
                                             // [19:12] byte1, [27:20] byte2, zero pad
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [0] kind, [1] sysex_end
  output logic                   out_tlast   // chunk_end
);

  logic in_acc;
  logic adv;

  logic              s1_valid_r;
  logic [PORT_W-1:0] s1_port_r;
  logic [7:0]        s1_byte_r;

  logic              byp_valid_r;
  logic [PORT_W-1:0] byp_addr_r;
  mbsp_state_t       byp_data_r;

  mbsp_state_t mem_rdata;
  mbsp_state_t cur_st;
  mbsp_state_t nxt_st;
  logic        upd_wr;
  logic        mem_we;
  mbsp_res_t   res;

  logic      out_valid_r;
  mbsp_res_t out_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  mbsp_state_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_tdata[PORT_W-1:0]),
    .rd_data (mem_rdata),
    .wr_en   (mem_we),
    .wr_addr (s1_port_r),
    .wr_data (nxt_st)
  );

  // The previous byte's write can land on the same edge as this byte's read.
  assign cur_st = (byp_valid_r && byp_addr_r == s1_port_r) ? byp_data_r : mem_rdata;

  mbsp_update u_update (
    .port    (s1_port_r),
    .rx_byte (s1_byte_r),
    .cur     (cur_st),
    .nxt     (nxt_st),
    .wr_en   (upd_wr),
    .res     (res)
  );

  assign mem_we = s1_valid_r && adv && upd_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      byp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_acc;
      end
      if (mem_we) begin
        byp_valid_r <= 1'b1;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r && res.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_port_r <= in_tdata[PORT_W-1:0];
      s1_byte_r <= in_tdata[PORT_W+7:PORT_W];
    end
    if (mem_we) begin
      byp_addr_r <= s1_port_r;
      byp_data_r <= nxt_st;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.byte2, out_r.byte1, out_r.byte0, out_r.msg_len, out_r.port};
  assign out_tuser  = {out_r.sysex_end, out_r.kind};
  assign out_tlast  = out_r.chunk_end;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled while the pipeline had room");

  a_sysex_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == KIND_SYSEX |->
      out_tdata[3:2] == 2'd0 && out_tdata[27:12] == 16'd0)
    else $error("SysEx item carries short-message fields");

  a_short_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == KIND_SHORT |->
      out_tdata[3:2] != 2'd0 && !out_tlast && !out_tuser[1])
    else $error("short message with bad length or SysEx marks");

  a_end_closes_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("SysEx end without chunk end");

endmodule

@@ rtl/core/mbsp_state_mem.sv @@
module mbsp_state_mem
  import mbsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [PORT_W-1:0] rd_addr,
  output mbsp_state_t       rd_data,
  input  logic              wr_en,
  input  logic [PORT_W-1:0] wr_addr,
  input  mbsp_state_t       wr_data
);

  mbsp_state_t mem [PORTS];
  logic [PORTS-1:0] vld_r;
  mbsp_state_t rdata_r;
  logic rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // An entry never written reads as the reset context.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rdata_r : '0;

endmodule

@@ rtl/core/mbsp_update.sv @@
module mbsp_update
  import mbsp_pkg::*;
(
  input  logic [PORT_W-1:0] port,
  input  logic [7:0]        rx_byte,
  input  mbsp_state_t       cur,
  output mbsp_state_t       nxt,
  output logic              wr_en,
  output mbsp_res_t         res
);

  always_comb begin
    logic [CNT_W:0] cnt;
    logic [CNT_W-1:0] base;
    logic [1:0] len;
    logic [7:0] hs;
    logic [1:0] ix;
    logic [1:0] ex;
    logic se;
    logic ce;

    nxt   = cur;
    wr_en = 1'b0;
    res   = '0;
    res.port = port;
    cnt  = '0;
    base = '0;
    len  = '0;
    hs   = cur.held_status;
    ix   = cur.byte_index;
    ex   = cur.expected_len;
    se   = 1'b0;
    ce   = 1'b0;

    if (int'(port) < PORTS) begin
      wr_en = 1'b1;
      if (rx_byte >= ST_REALTIME) begin
        res.emit    = 1'b1;
        res.kind    = KIND_SHORT;
        res.msg_len = 2'd1;
        res.byte0   = rx_byte;
      end else if (cur.sysex_active || rx_byte == ST_SYSEX) begin
        base = cur.chunk_count;
        if (!cur.sysex_active) begin
          nxt.sysex_active   = 1'b1;
          nxt.live_status    = '0;
          nxt.byte_index     = '0;
          nxt.expected_len   = '0;
          base = '0;
        end else begin
          se = (rx_byte == ST_EOX);
        end
        cnt = {1'b0, base} + 1'b1;
        ce  = (cnt >= (CNT_W+1)'(CHUNK)) || se;
        nxt.chunk_count = ce ? '0 : cnt[CNT_W-1:0];
        if (se) begin
          nxt.sysex_active = 1'b0;
        end
        res.emit      = 1'b1;
        res.kind      = KIND_SYSEX;
        res.byte0     = rx_byte;
        res.chunk_end = ce;
        res.sysex_end = se;
      end else if (rx_byte[7]) begin
        len = msg_length(rx_byte);
        if (len == 2'd1) begin
          nxt.live_status    = '0;
          nxt.byte_index     = '0;
          nxt.expected_len   = '0;
          res.emit    = 1'b1;
          res.kind    = KIND_SHORT;
          res.msg_len = 2'd1;
          res.byte0   = rx_byte;
        end else begin
          nxt.held_status    = rx_byte;
          nxt.byte_index     = 2'd1;
          nxt.expected_len   = len;
          nxt.live_status    = (rx_byte < ST_SYSEX) ? rx_byte : '0;
        end
      end else if (ex == 2'd0 && cur.live_status == '0) begin
        // Stray data byte with nothing to attach to.
        wr_en = 1'b0;
      end else begin
        if (ex == 2'd0) begin
          hs = cur.live_status;
          ix = 2'd1;
          ex = msg_length(cur.live_status);
        end
        nxt.held_status  = hs;
        nxt.byte_index   = ix;
        nxt.expected_len = ex;
        if (ix <= 2'd1) begin
          if (ex <= 2'd2) begin
            nxt.byte_index   = '0;
            nxt.expected_len = '0;
            res.emit    = 1'b1;
            res.kind    = KIND_SHORT;
            res.msg_len = 2'd2;
            res.byte0   = hs;
            res.byte1   = rx_byte;
          end else begin
            nxt.held_data  = rx_byte;
            nxt.byte_index = 2'd2;
          end
        end else begin
          nxt.byte_index   = '0;
          nxt.expected_len = '0;
          res.emit    = 1'b1;
          res.kind    = KIND_SHORT;
          res.msg_len = 2'd3;
          res.byte0   = hs;
          res.byte1   = cur.held_data;
          res.byte2   = rx_byte;
        end
      end
    end
  end

endmodule
